### rtl/pal_pkg.sv
`default_nettype none

package pal_pkg;

    // Fixed port widths
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int LEN_W   = 5;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Operation codes
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/positional_array_list.sv
// A result strobes on o_strobe in the cycle after start is taken.
// Throughput: one transaction per cycle; every list shift is done by the
// cell chain at once, so busy is never raised.
// The receiver cannot stall; results must be taken as they appear.
// Reset (synchronous, active low) empties the list, sets the capacity
// limit to 16 and drops o_strobe; stored words are not cleared.
`default_nettype none

module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         i_action,
    input  wire  [POS_W-1:0]   i_position,
    input  wire  [VAL_W-1:0]   i_element_value,
    input  wire                i_cfg_we,
    input  wire  [LIMIT_W-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output logic               o_done_res,
    output logic [VAL_W-1:0]   o_read_value,
    output logic [LEN_W-1:0]   o_list_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int EW = (WORD_WIDTH > VAL_W) ? WORD_WIDTH : VAL_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    logic [LIMIT_W-1:0]    r_limit;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_strobe;
    logic                  r_done;
    logic                  n_done;
    logic [VAL_W-1:0]      r_rd;
    logic [VAL_W-1:0]      n_rd;
    logic [LEN_W-1:0]      r_len;

    t_cell_ctl             ctl;
    logic                  accept;
    logic [XW-1:0]         count_x;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         limit_x;
    logic [XW-1:0]         n_count_x;
    logic [EW-1:0]         word_ext;
    logic [WORD_WIDTH-1:0] word;
    logic [WORD_WIDTH-1:0] rd_word;
    logic [EW-1:0]         rd_ext;
    logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
    logic [WORD_WIDTH-1:0] cell_tap  [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign count_x  = XW'(r_count);
    assign pos_x    = XW'(i_position);
    assign limit_x  = XW'(r_limit);
    assign word_ext = EW'(i_element_value);
    assign word     = word_ext[WORD_WIDTH-1:0];

    // Capacity limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // OR bus over the cell taps; at most one cell drives
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_word = rd_word | cell_tap[k];
        end
    end
    assign rd_ext = EW'(rd_word);

    // Operation decode and length update
    always_comb begin
        ctl.ins = 1'b0;
        ctl.rem = 1'b0;
        ctl.pos = i_position;
        n_count = r_count;
        n_done  = 1'b0;
        n_rd    = '0;
        if (accept) begin
            case (i_action)
                ACT_INSERT: begin
                    if (count_x < limit_x && count_x < CAP_X && pos_x <= count_x) begin
                        ctl.ins = 1'b1;
                        n_count = r_count + CW'(1);
                        n_done  = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (pos_x < count_x) begin
                        ctl.rem = 1'b1;
                        n_count = r_count - CW'(1);
                        n_done  = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (pos_x < count_x && pos_x < CAP_X) begin
                        n_rd   = rd_ext[VAL_W-1:0];
                        n_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
    assign n_count_x = XW'(n_count);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done <= n_done;
            r_rd   <= n_rd;
            r_len  <= n_count_x[LEN_W-1:0];
        end
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] left;
        logic [WORD_WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end
        pal_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_word  (word),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    assign o_strobe      = r_strobe;
    assign o_done_res    = r_done;
    assign o_read_value  = r_rd;
    assign o_list_length = r_len;

endmodule

`default_nettype wire

### rtl/pal_cell.sv
`default_nettype none

module pal_cell
    import pal_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  wire                   i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire  [WORD_WIDTH-1:0] i_word,
    input  wire  [WORD_WIDTH-1:0] i_left,
    input  wire  [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_data,
    output logic [WORD_WIDTH-1:0] o_tap
);

    logic [WORD_WIDTH-1:0] r_data;
    logic [WORD_WIDTH-1:0] n_data;
    logic                  above;
    logic                  here;

    assign above = int'(i_ctl.pos) < IDX;
    assign here  = int'(i_ctl.pos) == IDX;

    // Insert: cells above the slot take from the left, the slot takes the word.
    // Remove: the slot and cells above take from the right.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (above) begin
                n_data = i_left;
            end else if (here) begin
                n_data = i_word;
            end
        end else if (i_ctl.rem) begin
            if (above || here) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Read tap: only the addressed cell drives its word onto the OR bus
    assign o_tap  = here ? r_data : '0;

endmodule

`default_nettype wire

### rtl/pal_checker.sv
`default_nettype none

module pal_checker
    import pal_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input wire [1:0]         i_action,
    input wire               o_strobe,
    input wire               o_done_res,
    input wire [VAL_W-1:0]   o_read_value,
    input wire [LEN_W-1:0]   o_list_length
);

    // Every accepted transaction gives a result in the cycle after
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("accepted transaction without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without transaction");

    // Only a successful read carries a word
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (!o_done_res || $past(i_action) != ACT_READ)) |-> o_read_value == '0)
        else $error("nonzero word on a result that is not a read");

    // A refused or read transaction leaves the length unchanged
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && (!o_done_res || $past(i_action) == ACT_READ))
        |-> o_list_length == $past(o_list_length))
        else $error("length changed without insert or remove");

    // Reset drops the result strobe
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_action      (i_action),
    .o_strobe      (o_strobe),
    .o_done_res    (o_done_res),
    .o_read_value  (o_read_value),
    .o_list_length (o_list_length)
);

`default_nettype wire

### tb/tb_positional_array_list.sv
`timescale 1ns / 100ps

module tb_positional_array_list;
    import pal_pkg::*;

    localparam int CAP         = 16;
    localparam int CYCLE_LIMIT = 50000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // What the command queue can hold: a list transaction, a limit write, or a drain
    typedef enum logic [1:0] {
        SLOT_OP,
        SLOT_CFG,
        SLOT_DRAIN
    } t_slot_kind;

    typedef struct packed {
        t_slot_kind         kind;
        logic [1:0]         action;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   word;
        logic [LIMIT_W-1:0] limit;
        logic [6:0]         idle_pct;
    } t_cmd;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] rdval;
        logic [LEN_W-1:0] len;
    } t_outcome;

    typedef struct packed {
        logic [CAP-1:0][VAL_W-1:0] words;
        logic [LEN_W-1:0]          count;
        logic [LIMIT_W-1:0]        limit;
    } t_list;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic [VAL_W-1:0]   i_element_value = '0;
    logic               i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;
    logic               o_strobe;
    logic               o_done_res;
    logic [VAL_W-1:0]   o_read_value;
    logic [LEN_W-1:0]   o_list_length;

    t_cmd     cmd_q[$];
    t_outcome outcome_q[$];
    t_list    model_list;
    t_list    plan_list;
    logic     growing;
    int       cur_idle;
    int       cycle_cnt = 0;
    int       n_errors = 0;
    int       n_results = 0;
    int       n_done = 0;
    int       n_at_cap = 0;
    int       n_cfg = 0;

    positional_array_list #(
        .CAPACITY   (CAP),
        .WORD_WIDTH (VAL_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_done_res      (o_done_res),
        .o_read_value    (o_read_value),
        .o_list_length   (o_list_length)
    );

    always #2 i_clk = ~i_clk;

    // List behavior: apply one transaction to a list and return its outcome
    function automatic t_outcome apply_list_op(inout t_list st, input logic [1:0] act,
                                               input logic [POS_W-1:0] pos,
                                               input logic [VAL_W-1:0] word);
        t_outcome res;
        int       lim;
        int       i;
        res = '0;
        lim = (st.limit > CAP) ? CAP : int'(st.limit);
        case (act)
            ACT_INSERT: begin
                // full covers a limit of zero and a limit lowered below the length
                if (st.count < lim && pos <= st.count) begin
                    for (i = int'(st.count); i > int'(pos); i--)
                        st.words[i] = st.words[i-1];
                    st.words[pos] = word;
                    st.count = st.count + 1'b1;
                    res.done = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (pos < st.count) begin
                    for (i = int'(pos); i + 1 < int'(st.count); i++)
                        st.words[i] = st.words[i+1];
                    st.count = st.count - 1'b1;
                    res.done = 1'b1;
                end
            end
            ACT_READ: begin
                if (pos < st.count) begin
                    res.rdval = st.words[pos];
                    res.done  = 1'b1;
                end
            end
            default: ;  // unused code: refused
        endcase
        res.len = st.count;
        return res;
    endfunction

    // Queue a list transaction; the plan copy tracks the length for position picks
    task automatic push_op(input logic [1:0] act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] word);
        t_cmd c;
        c = '0;
        c.kind     = SLOT_OP;
        c.action   = act;
        c.position = pos;
        c.word     = word;
        c.idle_pct = 7'(cur_idle);
        void'(apply_list_op(plan_list, act, pos, word));
        cmd_q.push_back(c);
    endtask

    task automatic push_cfg(input logic [LIMIT_W-1:0] lim);
        t_cmd c;
        c = '0;
        c.kind  = SLOT_CFG;
        c.limit = lim;
        plan_list.limit = lim;
        cmd_q.push_back(c);
    endtask

    // One stretch of random traffic under a given limit
    task automatic gen_chunk(input int n, input logic [LIMIT_W-1:0] lim);
        t_cmd             c;
        int               k;
        int               pick;
        int               eff;
        logic [1:0]       act;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] word;
        push_cfg(lim);
        for (k = 0; k < n; k++) begin
            // halfway through, hold off until the list has answered everything
            if (k == n / 2) begin
                c = '0;
                c.kind = SLOT_DRAIN;
                cmd_q.push_back(c);
            end
            eff = (plan_list.limit > CAP) ? CAP : int'(plan_list.limit);
            if (growing && plan_list.count >= eff)
                growing = 1'b0;
            else if (!growing && plan_list.count == 0)
                growing = 1'b1;
            pick = $urandom_range(99, 0);
            if (pick < 5)
                act = ACT_UNUSED;
            else if (pick < 30)
                act = ACT_READ;
            else if (pick < 85)
                act = growing ? ACT_INSERT : ACT_REMOVE;
            else
                act = growing ? ACT_REMOVE : ACT_INSERT;
            // mostly in-range positions, some anywhere in the field
            if ($urandom_range(99, 0) < 15)
                pos = POS_W'($urandom_range(31, 0));
            else if (act == ACT_INSERT)
                pos = POS_W'($urandom_range(plan_list.count, 0));
            else if (plan_list.count == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(plan_list.count - 1, 0));
            pick = $urandom_range(9, 0);
            if (pick == 0)
                word = '1;
            else if (pick == 1)
                word = '0;
            else
                word = $urandom;
            push_op(act, pos, word);
        end
    endtask

    // Driver: issues queued transactions, idles at random, writes the limit when drained
    always @(posedge i_clk) begin : driver
        t_cmd     head;
        t_outcome res;
        logic     nxt_start;
        logic     nxt_we;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        if (!i_rst_n) begin
            model_list.count = '0;
            model_list.limit = LIMIT_RESET;
        end else begin
            if (start && !busy) begin
                res = apply_list_op(model_list, i_action, i_position, i_element_value);
                outcome_q.push_back(res);
            end
            if (i_cfg_we) begin
                model_list.limit = i_cfg_wdata;
                n_cfg++;
            end
            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (cmd_q.size() > 0) begin
                head = cmd_q[0];
                if (head.kind == SLOT_OP) begin
                    if ($urandom_range(99, 0) >= head.idle_pct) begin
                        void'(cmd_q.pop_front());
                        i_action        <= head.action;
                        i_position      <= head.position;
                        i_element_value <= head.word;
                        nxt_start = 1'b1;
                    end
                end else if (outcome_q.size() == 0) begin
                    void'(cmd_q.pop_front());
                    if (head.kind == SLOT_CFG) begin
                        i_cfg_wdata <= head.limit;
                        nxt_we = 1'b1;
                    end
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: every strobed result is matched against the oldest outcome
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                $error("unexpected result: done_res %0d read_value %h list_length %0d",
                       o_done_res, o_read_value, o_list_length);
                n_errors++;
            end else begin
                want = outcome_q.pop_front();
                if (want.done)
                    n_done++;
                if (want.len == CAP)
                    n_at_cap++;
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    n_errors++;
                end
                if (o_read_value !== want.rdval) begin
                    $error("read_value: expected %h, got %h", want.rdval, o_read_value);
                    n_errors++;
                end
                if (o_list_length !== want.len) begin
                    $error("list_length: expected %0d, got %0d", want.len, o_list_length);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("positional_array_list test failed");
            $finish;
        end
    end

    initial begin
        plan_list       = '0;
        plan_list.limit = LIMIT_RESET;
        model_list      = '0;
        growing         = 1'b1;
        cur_idle        = 25;

        // Directed: empty list, ends and middle, bad positions, unused code
        push_op(ACT_READ, 5'd0, 32'hDEAD_BEEF);
        push_op(ACT_REMOVE, 5'd0, 32'h0);
        push_op(ACT_INSERT, 5'd1, 32'h1111_1111);
        push_op(ACT_INSERT, 5'd0, 32'hFFFF_FFFF);
        push_op(ACT_INSERT, 5'd0, 32'h0000_0000);
        push_op(ACT_INSERT, 5'd2, 32'h5A5A_A5A5);
        push_op(ACT_INSERT, 5'd1, 32'h1234_5678);
        push_op(ACT_READ, 5'd0, 32'h0);
        push_op(ACT_READ, 5'd1, 32'h0);
        push_op(ACT_READ, 5'd2, 32'h0);
        push_op(ACT_READ, 5'd3, 32'h0);
        push_op(ACT_READ, 5'd4, 32'h0);
        push_op(ACT_READ, 5'd31, 32'h0);
        push_op(ACT_UNUSED, 5'd0, 32'hFFFF_FFFF);
        push_op(ACT_REMOVE, 5'd1, 32'h0);
        push_op(ACT_REMOVE, 5'd5, 32'h0);
        // limit dropped below the current length
        push_cfg(5'd2);
        push_op(ACT_INSERT, 5'd0, 32'hCAFE_0001);
        push_op(ACT_READ, 5'd2, 32'h0);
        push_op(ACT_REMOVE, 5'd0, 32'h0);
        push_op(ACT_INSERT, 5'd0, 32'hCAFE_0002);
        // zero limit refuses every insert
        push_cfg(5'd0);
        push_op(ACT_INSERT, 5'd0, 32'hCAFE_0003);
        push_op(ACT_REMOVE, 5'd1, 32'h0);
        // limit above the depth is capped
        push_cfg(5'd31);
        push_op(ACT_INSERT, 5'd1, 32'h8000_0001);
        push_op(ACT_READ, 5'd1, 32'h0);

        // Random: sender idles 25%, then 55%, then not at all
        gen_chunk(61, 5'd16);
        gen_chunk(61, 5'd1);
        gen_chunk(61, 5'($urandom_range(15, 2)));
        cur_idle = 55;
        gen_chunk(61, 5'd31);
        gen_chunk(61, 5'd0);
        gen_chunk(61, 5'($urandom_range(30, 17)));
        cur_idle = 0;
        gen_chunk(61, 5'd16);
        gen_chunk(61, 5'($urandom_range(15, 2)));
        gen_chunk(61, 5'd16);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (cmd_q.size() != 0 || start || outcome_q.size() != 0);
        repeat (4) @(posedge i_clk);

        $display("checked %0d results: %0d performed, %0d refused, %0d at full depth",
                 n_results, n_done, n_results - n_done, n_at_cap);
        $display("%0d capacity-limit writes across idle rates of 25, 55 and 0 percent",
                 n_cfg);
        if (n_errors == 0)
            $display("positional_array_list test passed");
        else
            $display("positional_array_list test failed");
        $finish;
    end

endmodule

### positional_array_list.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/positional_array_list.sv
rtl/pal_checker.sv
tb/tb_positional_array_list.sv
